// ===== sv/c2p_pkg.sv =====
`timescale 1ns / 1ps
package c2p_pkg;
   localparam int PIXELS_PER_WORD   = 16;
   localparam int DEF_PLANE_COUNT   = 4;
   localparam int PIXEL_W           = 8;
   localparam int ADDR_W            = 16;
   localparam int WORD_W            = PIXELS_PER_WORD;
   localparam int SHIFT_W           = PIXELS_PER_WORD - 1;
   localparam int PLANE_IDX_W       = 2;
   localparam int PIG_W             = $clog2(PIXELS_PER_WORD);
   localparam int GROUP_W           = 6;
   localparam int GPR_W             = 7;
   localparam int STRIDE_W          = 11;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 11;

   localparam logic [GPR_W-1:0]    GPR_RESET    = 7'd16;
   localparam logic [GPR_W-1:0]    MAX_GROUPS   = 7'd64;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd80;
   localparam logic [PIG_W-1:0]    LAST_PIXEL   = PIG_W'(PIXELS_PER_WORD - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_GROUPS_PER_ROW   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_STRIDE_WORDS = 2'd1;

   typedef struct packed {
      logic              step;
      logic              done;
      logic [ADDR_W-1:0] grp_addr;
   } cmd_type;

   typedef struct packed {
      logic                   valid;
      logic [ADDR_W-1:0]      addr;
      logic [WORD_W-1:0]      word;
      logic [PLANE_IDX_W-1:0] idx;
      logic                   last;
   } slot_type;
endpackage

// ===== sv/c2p_req_if.sv =====
`timescale 1ns / 1ps
interface c2p_req_if
   import c2p_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               start_of_frame;

   modport source (output valid, output pixel, output start_of_frame, input ready);
   modport sink (input valid, input pixel, input start_of_frame, output ready);
endinterface

// ===== sv/c2p_rsp_if.sv =====
`timescale 1ns / 1ps
interface c2p_rsp_if
   import c2p_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ADDR_W-1:0]      word_address;
   logic [WORD_W-1:0]      plane_word;
   logic [PLANE_IDX_W-1:0] plane_index;
   logic                   last_of_group;

   modport source (output valid, output word_address, output plane_word,
                   output plane_index, output last_of_group, input ready);
   modport sink (input valid, input word_address, input plane_word,
                 input plane_index, input last_of_group, output ready);
endinterface

// ===== sv/c2p_csr_if.sv =====
`timescale 1ns / 1ps
interface c2p_csr_if
   import c2p_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/c2p_ctrl.sv =====
`timescale 1ns / 1ps
module c2p_ctrl
   import c2p_pkg::*;
#(
   parameter int PLANE_COUNT = DEF_PLANE_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   sof,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cmd_type                cmd,
   output logic                   group_full
);
   logic [PIG_W-1:0]    pig_ff, pig_in, pig_cur;
   logic [GROUP_W-1:0]  grp_ff, grp_in, grp_cur;
   logic [ADDR_W-1:0]   base_ff, base_in, base_cur;
   logic [ADDR_W-1:0]   gaddr_ff, gaddr_in, gaddr_cur;
   logic [GPR_W-1:0]    gpr_ff, gpr_in, eff_groups;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic                done, row_end;

   always_comb begin
      pig_cur   = sof ? '0 : pig_ff;
      grp_cur   = sof ? '0 : grp_ff;
      base_cur  = sof ? '0 : base_ff;
      gaddr_cur = sof ? '0 : gaddr_ff;
      done      = (pig_cur == LAST_PIXEL);

      if (gpr_ff == '0) begin
         eff_groups = GPR_W'(1);
      end else if (gpr_ff > MAX_GROUPS) begin
         eff_groups = MAX_GROUPS;
      end else begin
         eff_groups = gpr_ff;
      end
      row_end = ({1'b0, grp_cur} + GPR_W'(1)) >= eff_groups;

      pig_in   = pig_ff;
      grp_in   = grp_ff;
      base_in  = base_ff;
      gaddr_in = gaddr_ff;
      if (accept) begin
         if (done) begin
            pig_in = '0;
            if (row_end) begin
               grp_in   = '0;
               base_in  = base_cur + ADDR_W'(stride_ff);
               gaddr_in = base_cur + ADDR_W'(stride_ff);
            end else begin
               grp_in   = grp_cur + GROUP_W'(1);
               base_in  = base_cur;
               gaddr_in = gaddr_cur + ADDR_W'(PLANE_COUNT);
            end
         end else begin
            pig_in   = pig_cur + PIG_W'(1);
            grp_in   = grp_cur;
            base_in  = base_cur;
            gaddr_in = gaddr_cur;
         end
      end

      gpr_in    = gpr_ff;
      stride_in = stride_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GROUPS_PER_ROW:   gpr_in    = csr_data[GPR_W-1:0];
            CSR_ROW_STRIDE_WORDS: stride_in = csr_data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pig_ff    <= '0;
         grp_ff    <= '0;
         base_ff   <= '0;
         gaddr_ff  <= '0;
         gpr_ff    <= GPR_RESET;
         stride_ff <= STRIDE_RESET;
      end else begin
         pig_ff    <= pig_in;
         grp_ff    <= grp_in;
         base_ff   <= base_in;
         gaddr_ff  <= gaddr_in;
         gpr_ff    <= gpr_in;
         stride_ff <= stride_in;
      end
   end

   assign cmd.step     = accept;
   assign cmd.done     = accept && done;
   assign cmd.grp_addr = gaddr_cur;
   assign group_full   = (pig_ff == LAST_PIXEL);
endmodule

// ===== sv/c2p_cell.sv =====
`timescale 1ns / 1ps
module c2p_cell
   import c2p_pkg::*;
#(
   parameter int PLANE       = 0,
   parameter int PLANE_COUNT = DEF_PLANE_COUNT
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  logic     pix_bit,
   input  logic     advance,
   input  slot_type slot_nxt,
   output slot_type slot
);
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   slot_type           slot_ff, slot_in;

   always_comb begin
      shift_in = cmd.step ? {shift_ff[SHIFT_W-2:0], pix_bit} : shift_ff;
      slot_in  = slot_ff;
      if (cmd.done) begin
         slot_in.valid = 1'b1;
         slot_in.addr  = cmd.grp_addr + ADDR_W'(PLANE);
         slot_in.word  = {shift_ff, pix_bit};
         slot_in.idx   = PLANE_IDX_W'(PLANE);
         slot_in.last  = (PLANE == PLANE_COUNT - 1);
      end else if (advance) begin
         slot_in = slot_nxt;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.addr <= slot_in.addr;
      slot_ff.word <= slot_in.word;
      slot_ff.idx  <= slot_in.idx;
      slot_ff.last <= slot_in.last;
   end

   assign slot = slot_ff;
endmodule

// ===== sv/chunky_to_planar_4bpp.sv =====
`timescale 1ns / 1ps
// Chunky to planar converter: takes one pixel word per clock and, on every sixteenth
// pixel of a group, loads one bitplane word per plane into a row of PLANE_COUNT cells;
// the cells then hand their words to the output one per clock while it is ready, plane 0
// first. With the output always ready the input never stalls (one pixel per cycle, four
// result words per sixteen pixels). An input word that would close a group waits while
// earlier plane words of the previous group are still in the cell row, so the rate under
// back-pressure is set by the cell row draining. Configuration writes take effect at once.
module chunky_to_planar_4bpp
   import c2p_pkg::*;
#(
   parameter int PLANE_COUNT = DEF_PLANE_COUNT
) (
   input logic        clock,
   input logic        reset,
   c2p_req_if.sink    req_ch,
   c2p_rsp_if.source  rsp_ch,
   c2p_csr_if.sink    csr_ch
);
   cmd_type                cmd;
   logic                   group_full;
   logic                   accept;
   logic                   advance;
   logic                   chain_free;
   slot_type               slots [PLANE_COUNT+1];
   logic [PLANE_COUNT-1:0] vmask;

   assign accept        = req_ch.valid && req_ch.ready;
   assign advance       = rsp_ch.valid && rsp_ch.ready;
   assign csr_ch.ready  = 1'b1;

   c2p_ctrl #(.PLANE_COUNT(PLANE_COUNT)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sof        (req_ch.start_of_frame),
      .csr_we     (csr_ch.valid && csr_ch.ready),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .cmd        (cmd),
      .group_full (group_full)
   );

   assign slots[PLANE_COUNT] = '0;

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
      c2p_cell #(.PLANE(p), .PLANE_COUNT(PLANE_COUNT)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .pix_bit  (req_ch.pixel[p]),
         .advance  (advance),
         .slot_nxt (slots[p+1]),
         .slot     (slots[p])
      );
      assign vmask[p] = slots[p].valid;
   end

   assign chain_free = ((vmask >> 1) == '0) && (!vmask[0] || rsp_ch.ready);
   assign req_ch.ready = !group_full || chain_free;

   assign rsp_ch.valid         = slots[0].valid;
   assign rsp_ch.word_address  = slots[0].addr;
   assign rsp_ch.plane_word    = slots[0].word;
   assign rsp_ch.plane_index   = slots[0].idx;
   assign rsp_ch.last_of_group = slots[0].last;

`ifndef SYNTHESIS
   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.done |=> rsp_ch.valid)
      else $error("group completion did not present a plane word");

   a_prefix: assert property (@(posedge clock) disable iff (reset)
      (vmask & (vmask + PLANE_COUNT'(1))) == '0)
      else $error("cell row holds a gap");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.done |-> chain_free)
      else $error("group loaded over pending plane words");
`endif
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import c2p_pkg::*;

   localparam int PLANES        = DEF_PLANE_COUNT;
   localparam int IDLE_LIMIT    = 3000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int TAIL_CYCLES   = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 60;
   localparam int RANDOM_ITEMS  = 120;
   localparam int MIN_WORDS     = 24;
   localparam int PHASE_ITEMS   = 30;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0]      addr;
      logic [WORD_W-1:0]      word;
      logic [PLANE_IDX_W-1:0] idx;
      logic                   last;
   } plane_word_type;

   class bitplane_tracker_type;
      logic [GPR_W-1:0]    groups_per_row;
      logic [STRIDE_W-1:0] row_stride;
      logic [SHIFT_W-1:0]  plane_bits [PLANES];
      logic [PIG_W-1:0]    pixel_count;
      logic [GROUP_W-1:0]  group_idx;
      logic [ADDR_W-1:0]   row_base;
      plane_word_type      pending_words [$];
      int                  errors;
      int                  pixels_taken;
      int                  words_made;
      int                  words_checked;

      function new();
         groups_per_row = GPR_RESET;
         row_stride     = STRIDE_RESET;
         clear_frame();
         errors        = 0;
         pixels_taken  = 0;
         words_made    = 0;
         words_checked = 0;
      endfunction

      function void clear_frame();
         foreach (plane_bits[p]) plane_bits[p] = '0;
         pixel_count = '0;
         group_idx   = '0;
         row_base    = '0;
      endfunction

      function void write_reg(input logic [CSR_INDEX_W-1:0] index,
                              input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GROUPS_PER_ROW:   groups_per_row = data[GPR_W-1:0];
            CSR_ROW_STRIDE_WORDS: row_stride = data[STRIDE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [GPR_W-1:0] row_groups();
         if (groups_per_row == '0) return GPR_W'(1);
         if (groups_per_row > MAX_GROUPS) return MAX_GROUPS;
         return groups_per_row;
      endfunction

      function void absorb_pixel(input logic [PIXEL_W-1:0] pixel, input logic sof);
         plane_word_type w;
         pixels_taken++;
         if (sof) clear_frame();
         if (pixel_count < LAST_PIXEL) begin
            for (int p = 0; p < PLANES; p++)
               plane_bits[p] = {plane_bits[p][SHIFT_W-2:0], pixel[p]};
            pixel_count = pixel_count + 1'b1;
         end else begin
            for (int p = 0; p < PLANES; p++) begin
               w.addr = row_base + ADDR_W'(PLANES * int'(group_idx) + p);
               w.word = {plane_bits[p], pixel[p]};
               w.idx  = PLANE_IDX_W'(p);
               w.last = (p == PLANES - 1);
               pending_words.push_back(w);
               plane_bits[p] = '0;
            end
            words_made += PLANES;
            pixel_count = '0;
            if ({1'b0, group_idx} + 7'd1 >= row_groups()) begin
               group_idx = '0;
               row_base  = row_base + ADDR_W'(row_stride);
            end else begin
               group_idx = group_idx + 1'b1;
            end
         end
      endfunction

      task flag_mismatch(input string msg);
         errors++;
         if (errors <= 100) $display("mismatch: %s", msg);
      endtask

      task match_plane_word(input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] word,
                            input logic [PLANE_IDX_W-1:0] idx,
                            input logic last);
         plane_word_type want;
         words_checked++;
         if (pending_words.size() == 0) begin
            flag_mismatch($sformatf("word %0d: addr %h word %h plane %0d last %0b, none expected",
                                    words_checked, addr, word, idx, last));
            return;
         end
         want = pending_words.pop_front();
         if (addr !== want.addr || word !== want.word || idx !== want.idx
             || last !== want.last)
            flag_mismatch($sformatf("word %0d: addr %h word %h plane %0d last %0b, want %h %h %0d %0b",
                                    words_checked, addr, word, idx, last,
                                    want.addr, want.word, want.idx, want.last));
      endtask
   endclass

   logic clock;
   logic reset;

   c2p_req_if req_if ();
   c2p_rsp_if rsp_if ();
   c2p_csr_if csr_if ();

   chunky_to_planar_4bpp DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   bitplane_tracker_type tracker;
   int                   items_sent;
   int                   idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int random_frame_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16 * $urandom_range(1, 3);
      return $urandom_range(1, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (csr_if.valid && csr_if.ready)
            tracker.write_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            tracker.absorb_pixel(req_if.pixel, req_if.start_of_frame);
         if (rsp_if.valid && rsp_if.ready)
            tracker.match_plane_word(rsp_if.word_address, rsp_if.plane_word,
                                     rsp_if.plane_index, rsp_if.last_of_group);
         if ((csr_if.valid && csr_if.ready) || (req_if.valid && req_if.ready)
             || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      int  burst;
      int  gap;
      bit  held;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
         repeat (burst) begin
            @(negedge clock);
            rsp_if.ready <= 1'b1;
         end
         if (!held && tracker.pixels_taken >= HOLD_AFTER) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else begin
            gap = pick_gap();
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic sof,
                             input bit quiet);
      int gap;
      gap = quiet ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid          <= 1'b1;
      req_if.pixel          <= pixel;
      req_if.start_of_frame <= sof;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic send_frame(input int length, input bit noise);
      bit   quiet;
      logic sof;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < length; i++) begin
         sof = (i == 0) || (noise && $urandom_range(0, 99) < 3);
         send_pixel(PIXEL_W'($urandom), sof, quiet);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_layout(input logic [GPR_W-1:0] groups,
                             input logic [STRIDE_W-1:0] stride);
      drain();
      write_csr(CSR_GROUPS_PER_ROW, {4'($urandom), groups});
      write_csr(CSR_ROW_STRIDE_WORDS, stride);
   endtask

   initial begin
      logic [PIXEL_W-1:0]  directed_pixels [16];
      logic [GPR_W-1:0]    groups;
      logic [STRIDE_W-1:0] stride;
      int                  phase;
      int                  first;
      int                  directed;

      directed_pixels = '{8'hff, 8'h00, 8'h0f, 8'hf0, 8'h01, 8'h02, 8'h04, 8'h08,
                          8'h0e, 8'h0d, 8'h0b, 8'h07, 8'ha5, 8'h5a, 8'hff, 8'h00};
      tracker    = new();
      items_sent = 0;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.pixel          = '0;
      req_if.start_of_frame = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.index          = '0;
      csr_if.data           = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one full group at reset layout, extreme pixels with high bits set
      for (int i = 0; i < 16; i++)
         send_pixel(directed_pixels[i], i == 0, 1'b0);

      set_layout(GPR_W'(1), STRIDE_W'(0));
      write_csr(CSR_SPARE_A, '1);
      write_csr(CSR_SPARE_B, '1);

      // back-to-back frame starts, then a partial group dropped by the next frame
      send_pixel(8'h3c, 1'b1, 1'b0);
      send_pixel(8'hc3, 1'b1, 1'b0);
      send_pixel(8'h99, 1'b1, 1'b0);
      send_pixel(8'h66, 1'b0, 1'b0);
      send_pixel(8'h81, 1'b0, 1'b0);
      directed = items_sent;

      phase = 0;
      while (items_sent < directed + RANDOM_ITEMS || tracker.words_made < MIN_WORDS) begin
         case (phase)
            0: begin groups = 7'd0;   stride = 11'd1024; end
            1: begin groups = 7'd127; stride = 11'd2047; end
            2: begin groups = 7'd64;  stride = 11'd1;    end
            3: begin groups = 7'd1;   stride = 11'd0;    end
            4: begin groups = 7'd2;   stride = 11'd1023; end
            default: begin
               groups = GPR_W'($urandom_range(0, 5));
               stride = STRIDE_W'($urandom_range(0, 2047));
            end
         endcase
         set_layout(groups, stride);
         first = items_sent;
         while (items_sent - first < PHASE_ITEMS)
            send_frame(random_frame_length(), 1'b1);
         phase++;
      end

      set_layout(GPR_RESET, STRIDE_RESET);
      send_frame(32, 1'b1);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_words.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ===== files.f =====
sv/c2p_pkg.sv
sv/c2p_req_if.sv
sv/c2p_rsp_if.sv
sv/c2p_csr_if.sv
sv/c2p_ctrl.sv
sv/c2p_cell.sv
sv/chunky_to_planar_4bpp.sv
tb/tb_top.sv
